@@ rtl/core/ose_pkg.sv @@
// ----------------------------------------------------------------------------
// ose_pkg
// Shared types, command codes and status codes for the operand stack engine.
// ----------------------------------------------------------------------------
package ose_pkg;

   localparam int STACK_DEPTH_DEF = 512;
   localparam int VALUE_BITS_DEF  = 32;

   // command codes
   localparam logic [3:0] FN_PUSH        = 4'd0;
   localparam logic [3:0] FN_POP         = 4'd1;
   localparam logic [3:0] FN_EXCH        = 4'd2;
   localparam logic [3:0] FN_DUP         = 4'd3;
   localparam logic [3:0] FN_COPY        = 4'd4;
   localparam logic [3:0] FN_INDEX       = 4'd5;
   localparam logic [3:0] FN_ROLL        = 4'd6;
   localparam logic [3:0] FN_CLEAR       = 4'd7;
   localparam logic [3:0] FN_COUNT       = 4'd8;
   localparam logic [3:0] FN_CLEARTOMARK = 4'd9;
   localparam logic [3:0] FN_COUNTTOMARK = 4'd10;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RANGE     = 3'd1;
   localparam logic [2:0] ST_UNDER     = 3'd2;
   localparam logic [2:0] ST_OVER      = 3'd3;
   localparam logic [2:0] ST_UNMATCHED = 3'd4;

   // element tags
   localparam logic [3:0] TAG_INT  = 4'd0;
   localparam logic [3:0] TAG_MARK = 4'd1;

   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic [3:0]         func;
      logic [3:0]         push_tag;
      logic [31:0]        push_value;
      logic signed [31:0] count_arg;
      logic signed [31:0] shift_arg;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  stack_level;
      logic [3:0]  top_tag;
      logic [31:0] top_value;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_PUSH_REQ, OP_POP, OP_PUSH_CNT, OP_PUSH_TMARK,
      OP_CLEAR, OP_SET_SP_A, OP_SET_SP_B, OP_SETAB_EXCH, OP_SETA_DUP,
      OP_SETA_IDX, OP_SETUP_COPY, OP_RD_A, OP_RD_B, OP_W_A, OP_W_B,
      OP_PUSH_RD, OP_W_COPY, OP_DIV_INIT, OP_DIV_STEP, OP_ROLL_S,
      OP_REV0, OP_REV1, OP_REV2, OP_DEC_B, OP_SCAN_INIT, OP_DEC_A,
      OP_RD_TOP, OP_OUT_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       st_we;
      logic [2:0] st;
   } cmd_type;

   typedef struct packed {
      logic [3:0] func;
      logic       full;
      logic       sp_lt1;
      logic       sp_lt2;
      logic       n_neg;
      logic       n_zero;
      logic       n_gt_sp;
      logic       n_ge_sp;
      logic       copy_over;
      logic       cnt_zero;
      logic       div_done;
      logic       s_zero;
      logic       rev_more;
      logic       a_zero;
      logic       rd_mark;
      logic       out_busy;
   } flags_type;

endpackage

@@ rtl/core/ose_ctrl.sv @@
// ----------------------------------------------------------------------------
// ose_ctrl
// Command sequencer: dispatches each request and walks the multi-step ones.
// ----------------------------------------------------------------------------
module ose_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ose_pkg::flags_type flags,
   output ose_pkg::cmd_type   cmd
);

   typedef enum logic [22:0] {
      S_IDLE      = 23'h000001,
      S_DISPATCH  = 23'h000002,
      S_SW_RA     = 23'h000004,
      S_SW_RB     = 23'h000008,
      S_SW_WA     = 23'h000010,
      S_SW_WB     = 23'h000020,
      S_IDX_RD    = 23'h000040,
      S_IDX_PUSH  = 23'h000080,
      S_COPY_CHK  = 23'h000100,
      S_COPY_RD   = 23'h000200,
      S_COPY_WR   = 23'h000400,
      S_DIV       = 23'h000800,
      S_ROLL_S    = 23'h001000,
      S_ROLL_CHK  = 23'h002000,
      S_REV_SET   = 23'h004000,
      S_REV_CHK   = 23'h008000,
      S_REV_DEC   = 23'h010000,
      S_SCAN_CHK  = 23'h020000,
      S_SCAN_DEC  = 23'h040000,
      S_SCAN_RD   = 23'h080000,
      S_SCAN_TEST = 23'h100000,
      S_TOP_RD    = 23'h200000,
      S_TOP_OUT   = 23'h400000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] phase_ff, phase_in;

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cmd.op    = ose_pkg::OP_NOP;
      cmd.st_we = 1'b0;
      cmd.st    = ose_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ose_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in  = S_TOP_RD;
            cmd.st_we = 1'b1;
            unique case (flags.func) inside
               ose_pkg::FN_PUSH: begin
                  if (flags.full) cmd.st = ose_pkg::ST_OVER;
                  else cmd.op = ose_pkg::OP_PUSH_REQ;
               end
               ose_pkg::FN_POP: begin
                  if (flags.sp_lt1) cmd.st = ose_pkg::ST_UNDER;
                  else cmd.op = ose_pkg::OP_POP;
               end
               ose_pkg::FN_EXCH: begin
                  if (flags.sp_lt2) cmd.st = ose_pkg::ST_UNDER;
                  else begin
                     cmd.op   = ose_pkg::OP_SETAB_EXCH;
                     state_in = S_SW_RA;
                  end
               end
               ose_pkg::FN_DUP: begin
                  if (flags.sp_lt1) cmd.st = ose_pkg::ST_UNDER;
                  else if (flags.full) cmd.st = ose_pkg::ST_OVER;
                  else begin
                     cmd.op   = ose_pkg::OP_SETA_DUP;
                     state_in = S_IDX_RD;
                  end
               end
               ose_pkg::FN_COPY: begin
                  if (flags.n_neg) cmd.st = ose_pkg::ST_RANGE;
                  else if (flags.n_gt_sp) cmd.st = ose_pkg::ST_UNDER;
                  else if (flags.copy_over) cmd.st = ose_pkg::ST_OVER;
                  else begin
                     cmd.op   = ose_pkg::OP_SETUP_COPY;
                     state_in = S_COPY_CHK;
                  end
               end
               ose_pkg::FN_INDEX: begin
                  if (flags.n_neg) cmd.st = ose_pkg::ST_RANGE;
                  else if (flags.n_ge_sp) cmd.st = ose_pkg::ST_UNDER;
                  else if (flags.full) cmd.st = ose_pkg::ST_OVER;
                  else begin
                     cmd.op   = ose_pkg::OP_SETA_IDX;
                     state_in = S_IDX_RD;
                  end
               end
               ose_pkg::FN_ROLL: begin
                  if (flags.n_neg) cmd.st = ose_pkg::ST_RANGE;
                  else if (flags.n_zero) cmd.st = ose_pkg::ST_OK;
                  else if (flags.n_gt_sp) cmd.st = ose_pkg::ST_UNDER;
                  else begin
                     cmd.op   = ose_pkg::OP_DIV_INIT;
                     state_in = S_DIV;
                  end
               end
               ose_pkg::FN_CLEAR: cmd.op = ose_pkg::OP_CLEAR;
               ose_pkg::FN_COUNT: begin
                  if (flags.full) cmd.st = ose_pkg::ST_OVER;
                  else cmd.op = ose_pkg::OP_PUSH_CNT;
               end
               ose_pkg::FN_CLEARTOMARK, ose_pkg::FN_COUNTTOMARK: begin
                  cmd.op   = ose_pkg::OP_SCAN_INIT;
                  state_in = S_SCAN_CHK;
               end
               default: ;
            endcase
         end
         // swap of entries a and b, shared by exch and roll
         S_SW_RA: begin
            cmd.op   = ose_pkg::OP_RD_A;
            state_in = S_SW_RB;
         end
         S_SW_RB: begin
            cmd.op   = ose_pkg::OP_RD_B;
            state_in = S_SW_WA;
         end
         S_SW_WA: begin
            cmd.op   = ose_pkg::OP_W_A;
            state_in = S_SW_WB;
         end
         S_SW_WB: begin
            cmd.op   = ose_pkg::OP_W_B;
            state_in = (flags.func == ose_pkg::FN_ROLL) ? S_REV_CHK : S_TOP_RD;
         end
         S_IDX_RD: begin
            cmd.op   = ose_pkg::OP_RD_A;
            state_in = S_IDX_PUSH;
         end
         S_IDX_PUSH: begin
            cmd.op   = ose_pkg::OP_PUSH_RD;
            state_in = S_TOP_RD;
         end
         S_COPY_CHK: begin
            if (flags.cnt_zero) begin
               cmd.op   = ose_pkg::OP_SET_SP_B;
               state_in = S_TOP_RD;
            end else begin
               state_in = S_COPY_RD;
            end
         end
         S_COPY_RD: begin
            cmd.op   = ose_pkg::OP_RD_A;
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            cmd.op   = ose_pkg::OP_W_COPY;
            state_in = S_COPY_CHK;
         end
         S_DIV: begin
            if (flags.div_done) state_in = S_ROLL_S;
            else cmd.op = ose_pkg::OP_DIV_STEP;
         end
         S_ROLL_S: begin
            cmd.op   = ose_pkg::OP_ROLL_S;
            state_in = S_ROLL_CHK;
         end
         S_ROLL_CHK: begin
            phase_in = 2'd0;
            state_in = flags.s_zero ? S_TOP_RD : S_REV_SET;
         end
         // three reversals: whole block, lower s entries, upper entries
         S_REV_SET: begin
            case (phase_ff)
               2'd0:    cmd.op = ose_pkg::OP_REV0;
               2'd1:    cmd.op = ose_pkg::OP_REV1;
               default: cmd.op = ose_pkg::OP_REV2;
            endcase
            state_in = S_REV_CHK;
         end
         S_REV_CHK: begin
            if (flags.rev_more) begin
               state_in = S_REV_DEC;
            end else if (phase_ff == 2'd2) begin
               state_in = S_TOP_RD;
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = S_REV_SET;
            end
         end
         S_REV_DEC: begin
            cmd.op   = ose_pkg::OP_DEC_B;
            state_in = S_SW_RA;
         end
         S_SCAN_CHK: begin
            if (flags.a_zero) begin
               cmd.st_we = 1'b1;
               cmd.st    = ose_pkg::ST_UNMATCHED;
               if (flags.func == ose_pkg::FN_CLEARTOMARK) cmd.op = ose_pkg::OP_CLEAR;
               state_in = S_TOP_RD;
            end else begin
               state_in = S_SCAN_DEC;
            end
         end
         S_SCAN_DEC: begin
            cmd.op   = ose_pkg::OP_DEC_A;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.op   = ose_pkg::OP_RD_A;
            state_in = S_SCAN_TEST;
         end
         S_SCAN_TEST: begin
            if (flags.rd_mark) begin
               state_in = S_TOP_RD;
               if (flags.func == ose_pkg::FN_CLEARTOMARK) begin
                  cmd.op = ose_pkg::OP_SET_SP_A;
               end else if (flags.full) begin
                  cmd.st_we = 1'b1;
                  cmd.st    = ose_pkg::ST_OVER;
               end else begin
                  cmd.op = ose_pkg::OP_PUSH_TMARK;
               end
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_TOP_RD: begin
            cmd.op   = ose_pkg::OP_RD_TOP;
            state_in = S_TOP_OUT;
         end
         S_TOP_OUT: begin
            if (!flags.out_busy) begin
               cmd.op   = ose_pkg::OP_OUT_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ rtl/core/ose_dp.sv @@
// ----------------------------------------------------------------------------
// ose_dp
// Stack storage, pointers, remainder unit and response register.
// ----------------------------------------------------------------------------
module ose_dp #(
   parameter int STACK_DEPTH = ose_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_BITS  = ose_pkg::VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ose_pkg::req_type   req_data,
   input  ose_pkg::cmd_type   cmd,
   output ose_pkg::flags_type flags,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ose_pkg::rsp_type   rsp_data
);

   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int EW = 4 + VALUE_BITS;

   logic [EW-1:0] mem [STACK_DEPTH];

   ose_pkg::req_type req_ff;
   ose_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic [PW-1:0]    sp_ff, a_ff, b_ff, cnt_ff, s_ff, rem_ff;
   logic [31:0]      quo_ff;
   logic [5:0]       dcnt_ff;
   logic [2:0]       st_ff;
   logic [EW-1:0]    rd_ff, tmp_ff;

   logic [31:0]     sp32, nu, ju, jabs;
   logic [32:0]     csum;
   logic [PW-1:0]   n_lo, base, sp_m1, tmark;
   logic [PW:0]     rem_sh, a_p1;
   logic            n_neg;
   logic            mem_we, mem_re;
   logic [AW-1:0]   waddr, raddr;
   logic [EW-1:0]   wdata;
   logic [VALUE_BITS+31:0] pv_wide, out_wide;
   logic [VALUE_BITS+PW-1:0] cnt_wide, tm_wide;
   logic [PW+9:0]   lvl_wide;

   assign sp32  = {{(32 - PW){1'b0}}, sp_ff};
   assign nu    = req_ff.count_arg;
   assign ju    = req_ff.shift_arg;
   assign n_neg = nu[31];
   assign jabs  = ju[31] ? (~ju + 32'd1) : ju;
   assign csum  = {1'b0, sp32} + {1'b0, nu};
   assign n_lo  = nu[PW-1:0];
   assign base  = sp_ff - n_lo;
   assign sp_m1 = sp_ff - {{(PW - 1){1'b0}}, 1'b1};
   assign tmark = sp_m1 - a_ff;
   assign rem_sh = {rem_ff, quo_ff[31]};
   assign a_p1  = {1'b0, a_ff} + {{PW{1'b0}}, 1'b1};

   assign pv_wide  = {{VALUE_BITS{1'b0}}, req_ff.push_value};
   assign cnt_wide = {{VALUE_BITS{1'b0}}, sp_ff};
   assign tm_wide  = {{VALUE_BITS{1'b0}}, tmark};
   assign out_wide = {32'd0, rd_ff[VALUE_BITS-1:0]};
   assign lvl_wide = {10'd0, sp_ff};

   always_comb begin
      flags.func      = req_ff.func;
      flags.full      = (sp_ff >= PW'(STACK_DEPTH));
      flags.sp_lt1    = (sp_ff == '0);
      flags.sp_lt2    = (sp_ff < PW'(2));
      flags.n_neg     = n_neg;
      flags.n_zero    = (nu == 32'd0);
      flags.n_gt_sp   = !n_neg && (nu > sp32);
      flags.n_ge_sp   = !n_neg && (nu >= sp32);
      flags.copy_over = (csum > 33'(STACK_DEPTH));
      flags.cnt_zero  = (cnt_ff == '0);
      flags.div_done  = (dcnt_ff == 6'd0);
      flags.s_zero    = (s_ff == '0);
      flags.rev_more  = (a_p1 < {1'b0, b_ff});
      flags.a_zero    = (a_ff == '0);
      flags.rd_mark   = (rd_ff[EW-1:VALUE_BITS] == ose_pkg::TAG_MARK);
      flags.out_busy  = rsp_valid_ff && !rsp_ready;
   end

   // storage port selection
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      waddr  = sp_ff[AW-1:0];
      raddr  = a_ff[AW-1:0];
      wdata  = rd_ff;
      case (cmd.op)
         ose_pkg::OP_PUSH_REQ: begin
            mem_we = 1'b1;
            wdata  = {req_ff.push_tag, pv_wide[VALUE_BITS-1:0]};
         end
         ose_pkg::OP_PUSH_CNT: begin
            mem_we = 1'b1;
            wdata  = {ose_pkg::TAG_INT, cnt_wide[VALUE_BITS-1:0]};
         end
         ose_pkg::OP_PUSH_TMARK: begin
            mem_we = 1'b1;
            wdata  = {ose_pkg::TAG_INT, tm_wide[VALUE_BITS-1:0]};
         end
         ose_pkg::OP_PUSH_RD: mem_we = 1'b1;
         ose_pkg::OP_W_COPY: begin
            mem_we = 1'b1;
            waddr  = b_ff[AW-1:0];
         end
         ose_pkg::OP_W_A: begin
            mem_we = 1'b1;
            waddr  = a_ff[AW-1:0];
         end
         ose_pkg::OP_W_B: begin
            mem_we = 1'b1;
            waddr  = b_ff[AW-1:0];
            wdata  = tmp_ff;
         end
         ose_pkg::OP_RD_A: mem_re = 1'b1;
         ose_pkg::OP_RD_B: begin
            mem_re = 1'b1;
            raddr  = b_ff[AW-1:0];
         end
         ose_pkg::OP_RD_TOP: begin
            mem_re = 1'b1;
            raddr  = sp_m1[AW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (mem_re) rd_ff <= mem[raddr];
      if (cmd.op == ose_pkg::OP_RD_B) tmp_ff <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == ose_pkg::OP_OUT_LOAD) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.st_we) st_ff <= cmd.st;
         case (cmd.op) inside
            ose_pkg::OP_LOAD: begin
               req_ff <= req_data;
               st_ff  <= ose_pkg::ST_OK;
            end
            ose_pkg::OP_PUSH_REQ, ose_pkg::OP_PUSH_CNT, ose_pkg::OP_PUSH_TMARK,
            ose_pkg::OP_PUSH_RD: sp_ff <= sp_ff + {{(PW - 1){1'b0}}, 1'b1};
            ose_pkg::OP_POP:      sp_ff <= sp_m1;
            ose_pkg::OP_CLEAR:    sp_ff <= '0;
            ose_pkg::OP_SET_SP_A: sp_ff <= a_ff;
            ose_pkg::OP_SET_SP_B: sp_ff <= b_ff;
            ose_pkg::OP_SETAB_EXCH: begin
               a_ff <= sp_m1;
               b_ff <= sp_ff - PW'(2);
            end
            ose_pkg::OP_SETA_DUP: a_ff <= sp_m1;
            ose_pkg::OP_SETA_IDX: a_ff <= sp_m1 - n_lo;
            ose_pkg::OP_SETUP_COPY: begin
               a_ff   <= base;
               b_ff   <= sp_ff;
               cnt_ff <= n_lo;
            end
            ose_pkg::OP_W_COPY: begin
               a_ff   <= a_p1[PW-1:0];
               b_ff   <= b_ff + {{(PW - 1){1'b0}}, 1'b1};
               cnt_ff <= cnt_ff - {{(PW - 1){1'b0}}, 1'b1};
            end
            ose_pkg::OP_W_B: a_ff <= a_p1[PW-1:0];
            // shift-subtract remainder of |j| by n, one bit a cycle
            ose_pkg::OP_DIV_INIT: begin
               quo_ff  <= jabs;
               rem_ff  <= '0;
               dcnt_ff <= 6'(ose_pkg::DIV_STEPS);
            end
            ose_pkg::OP_DIV_STEP: begin
               quo_ff  <= {quo_ff[30:0], 1'b0};
               dcnt_ff <= dcnt_ff - 6'd1;
               if (rem_sh >= {1'b0, n_lo}) rem_ff <= PW'(rem_sh - {1'b0, n_lo});
               else rem_ff <= rem_sh[PW-1:0];
            end
            // floor modulo: negative j with a nonzero remainder wraps
            ose_pkg::OP_ROLL_S: s_ff <= (ju[31] && rem_ff != '0) ? n_lo - rem_ff : rem_ff;
            ose_pkg::OP_REV0: begin
               a_ff <= base;
               b_ff <= sp_ff;
            end
            ose_pkg::OP_REV1: begin
               a_ff <= base;
               b_ff <= base + s_ff;
            end
            ose_pkg::OP_REV2: begin
               a_ff <= base + s_ff;
               b_ff <= sp_ff;
            end
            ose_pkg::OP_DEC_B:     b_ff <= b_ff - {{(PW - 1){1'b0}}, 1'b1};
            ose_pkg::OP_SCAN_INIT: a_ff <= sp_ff;
            ose_pkg::OP_DEC_A:     a_ff <= a_ff - {{(PW - 1){1'b0}}, 1'b1};
            ose_pkg::OP_OUT_LOAD: begin
               rsp_ff.status       <= st_ff;
               rsp_ff.stack_level  <= lvl_wide[9:0];
               rsp_ff.top_tag      <= (sp_ff == '0) ? 4'd0 : rd_ff[EW-1:VALUE_BITS];
               rsp_ff.top_value    <= (sp_ff == '0) ? 32'd0 : out_wide[31:0];
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/operand_stack_engine_top.sv @@
// ----------------------------------------------------------------------------
// operand_stack_engine_top
// Tagged operand stack that executes one stack command per request.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with the command, the element to push
// and the n and j arguments. Each request yields one response on
// rsp_valid/rsp_ready with status, new depth and the top element.
// One request is worked at a time; req_ready is high only while idle.
// Steps per request, between the load and the final top read and response:
//   push, pop, clear, count, error cases: the dispatch alone
//   dup, index: one storage read, then a push      exch: one swap
//   copy n: one storage read and write per copied element
//   roll n j: the remainder unit and setup; a nonzero shift adds the three
//             reversal passes, each made of swaps of entries a and b
//   cleartomark, counttomark: a scan of entries from the top toward the
//             nearest mark, ending at the bottom when no mark is found
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls with a response still pending, the next
// response waits in its final step until the register frees.
// Reset clears the stack pointer and drops any pending response; storage
// contents need no clearing since only entries below the pointer are read.
// ----------------------------------------------------------------------------
module operand_stack_engine_top #(
   parameter int STACK_DEPTH = ose_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_BITS  = ose_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ose_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ose_pkg::rsp_type rsp_data
);

   ose_pkg::cmd_type   cmd;
   ose_pkg::flags_type flags;

   ose_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   ose_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
